[src/chtb_pkg.sv]
// Package for the cuckoo hash table core: state codes, command and way codes,
// register map and the pre-modulo hash products. No dependencies.
`default_nettype none
package chtb_pkg;

    localparam int KEY_W   = 32;
    localparam int ENTRY_W = KEY_W + 1;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_ERASE  = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic [1:0] WAY_NONE   = 2'd0;
    localparam logic [1:0] WAY_FIRST  = 2'd1;
    localparam logic [1:0] WAY_SECOND = 2'd2;

    localparam logic [1:0] REG_TABLE_SIZE = 2'd0;
    localparam logic [1:0] REG_MAX_KICKS  = 2'd1;
    localparam logic [1:0] REG_LOAD_LIMIT = 2'd2;

    localparam logic [10:0] TABLE_SIZE_RST = 11'd1024;
    localparam logic [7:0]  MAX_KICKS_RST  = 8'd60;
    localparam logic [11:0] LOAD_LIMIT_RST = 12'd1024;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_HA,
        S_HB,
        S_RD,
        S_LOC,
        S_KRD,
        S_KCHK,
        S_KH,
        S_DONE
    } t_state;

    // 7*(k+3) with 32-bit wrap
    function automatic logic [31:0] f_prod_a(input logic [31:0] k);
        logic [31:0] x;
        x = k + 32'd3;
        return (x << 3) - x;
    endfunction

    // 5*(k+1) with 32-bit wrap
    function automatic logic [31:0] f_prod_b(input logic [31:0] k);
        logic [31:0] x;
        x = k + 32'd1;
        return (x << 2) + x;
    endfunction

endpackage
`default_nettype wire

[src/chtb_if.sv]
// Handshake channels of the cuckoo hash table core: command in, result out.
// Depends on nothing.
`default_nettype none
interface chtb_cmd_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  cmd;
    logic signed [31:0] key;
    modport source (output valid, cmd, key, input ready);
    modport sink   (input valid, cmd, key, output ready);
endinterface

interface chtb_res_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  way;
    logic               success;
    logic               kick_fail;
    logic signed [31:0] homeless_key;
    logic        [11:0] entry_count;
    logic               load_high;
    modport source (output valid, way, success, kick_fail, homeless_key, entry_count,
                    load_high, input ready);
    modport sink   (input valid, way, success, kick_fail, homeless_key, entry_count,
                    load_high, output ready);
endinterface
`default_nettype wire

[src/chtb_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module chtb_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[src/chtb_mod.sv]
// Iterative modulo unit: sign-extends a 32-bit product to 64 bits and reduces
// it by the table size, four bits per cycle. Uses chtb_pkg.
`default_nettype none
module chtb_mod
    import chtb_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [31:0]              i_value,
    input  wire logic [$clog2(DEPTH):0]   i_modulus,
    output logic                          o_done,
    output logic [$clog2(DEPTH)-1:0]      o_rem
);
    localparam int AW = $clog2(DEPTH);
    localparam int MW = AW + 1;

    logic [63:0]   r_sh, n_sh;
    logic [MW-1:0] r_rem, n_rem;
    logic [3:0]    r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [MW:0]   t;

    always_comb begin
        n_sh   = r_sh;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        t      = '0;
        if (i_start) begin
            n_sh   = {{32{i_value[31]}}, i_value};
            n_rem  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // four restoring steps on the top bits
            for (int i = 0; i < 4; i++) begin
                t = {n_rem, n_sh[63 - i]};
                if (t >= {1'b0, i_modulus}) begin
                    t = t - {1'b0, i_modulus};
                end
                n_rem = t[MW-1:0];
            end
            n_sh  = r_sh << 4;
            n_cnt = r_cnt + 4'd1;
            if (r_cnt == 4'd15) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_sh  <= n_sh;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[AW-1:0];
endmodule
`default_nettype wire

[src/cuckoo_hash_table_core.sv]
// Two-way cuckoo hash set of 32-bit keys.
// Commands arrive on i_cmd (valid/ready); one result beat per command leaves
// on o_res through an output register, so the next command is taken while a
// result still waits. Configuration is written over the APB port:
// table_size at 0x0, max_kicks at 0x4, load_limit at 0x8.
// One command is processed at a time. Both hashes use the shared modulo unit
// and the two table RAMs have registered reads. Work per command:
//   lookup / erase / insert of a stored key: two hashes, one read of both;
//   insert of a new key: a read and check per eviction (up to max_kicks);
//   clear: one entry of each table written per cycle.
// After reset the same sweep invalidates both tables; i_cmd ready stays low
// until it ends. When the receiver stalls, a finished result holds in the
// output register and the next command stops at completion until the
// register frees.
// Depends on chtb_pkg, chtb_if, chtb_ram and chtb_mod.
`default_nettype none
module cuckoo_hash_table_core
    import chtb_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    chtb_cmd_if.sink         i_cmd,
    chtb_res_if.source       o_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    localparam int AW = $clog2(DEPTH);
    localparam int MW = AW + 1;
    localparam int CW = $clog2(2 * DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    // configuration
    logic [10:0] r_table_size;
    logic [7:0]  r_max_kicks;
    logic [11:0] r_load_limit;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= TABLE_SIZE_RST;
            r_max_kicks  <= MAX_KICKS_RST;
            r_load_limit <= LOAD_LIMIT_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_TABLE_SIZE: r_table_size <= pwdata[10:0];
                REG_MAX_KICKS:  r_max_kicks  <= pwdata[7:0];
                REG_LOAD_LIMIT: r_load_limit <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_TABLE_SIZE: prdata = {21'd0, r_table_size};
            REG_MAX_KICKS:  prdata = {24'd0, r_max_kicks};
            REG_LOAD_LIMIT: prdata = {20'd0, r_load_limit};
            default:        prdata = '0;
        endcase
    end

    // active modulus: zero acts as one, clamp to DEPTH
    logic [MW-1:0] modulus;
    always_comb begin
        if (r_table_size == 11'd0) begin
            modulus = MW'(1);
        end else if (32'(r_table_size) > 32'(DEPTH)) begin
            modulus = MW'(DEPTH);
        end else begin
            modulus = MW'(r_table_size);
        end
    end

    // datapath state
    t_state         r_state, n_state;
    logic [1:0]     r_cmd, n_cmd;
    logic [31:0]    r_key, n_key;
    logic [AW-1:0]  r_ha, n_ha, r_hb, n_hb, r_idx, n_idx, r_clr_addr, n_clr_addr;
    logic           r_first, n_first;
    logic [7:0]     r_steps, n_steps;
    logic [CW-1:0]  r_count, n_count;
    logic [1:0]     r_way, n_way;
    logic           r_success, n_success, r_fail, n_fail, r_clr_pend, n_clr_pend;
    logic [31:0]    r_homeless, n_homeless;

    // output register
    logic           r_ov, n_ov;
    logic [1:0]     r_o_way;
    logic           r_o_success, r_o_fail, r_o_load;
    logic [31:0]    r_o_homeless;
    logic [11:0]    r_o_count;
    logic           load_out;

    // memories and modulo unit
    logic               we_a, we_b;
    logic [AW-1:0]      waddr, raddr_a, raddr_b;
    logic [ENTRY_W-1:0] wdata, rdata_a, rdata_b, rsel;
    logic               mod_start, mod_done;
    logic [31:0]        mod_val;
    logic [AW-1:0]      mod_rem;
    logic [1:0]         loc_way;
    logic [7:0]         steps_inc;

    chtb_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram_a (
        .i_clk(i_clk), .i_we(we_a), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr_a), .o_rdata(rdata_a)
    );
    chtb_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram_b (
        .i_clk(i_clk), .i_we(we_b), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr_b), .o_rdata(rdata_b)
    );
    chtb_mod #(.DEPTH(DEPTH)) u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mod_start), .i_value(mod_val),
        .i_modulus(modulus), .o_done(mod_done), .o_rem(mod_rem)
    );

    assign i_cmd.ready = (r_state == S_IDLE);
    assign rsel        = r_first ? rdata_a : rdata_b;
    assign steps_inc   = r_steps + 8'd1;

    always_comb begin
        if (rdata_a[KEY_W] && rdata_a[KEY_W-1:0] == r_key) begin
            loc_way = WAY_FIRST;
        end else if (rdata_b[KEY_W] && rdata_b[KEY_W-1:0] == r_key) begin
            loc_way = WAY_SECOND;
        end else begin
            loc_way = WAY_NONE;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_key      = r_key;
        n_ha       = r_ha;
        n_hb       = r_hb;
        n_idx      = r_idx;
        n_clr_addr = r_clr_addr;
        n_first    = r_first;
        n_steps    = r_steps;
        n_count    = r_count;
        n_way      = r_way;
        n_success  = r_success;
        n_fail     = r_fail;
        n_homeless = r_homeless;
        n_clr_pend = r_clr_pend;
        we_a       = 1'b0;
        we_b       = 1'b0;
        waddr      = r_idx;
        wdata      = {1'b1, r_key};
        raddr_a    = r_ha;
        raddr_b    = r_hb;
        mod_start  = 1'b0;
        mod_val    = f_prod_a(r_key);
        load_out   = 1'b0;
        unique case (r_state)
            S_CLR: begin
                we_a  = 1'b1;
                we_b  = 1'b1;
                waddr = r_clr_addr;
                wdata = '0;
                if (r_clr_addr == LAST_ADDR) begin
                    n_clr_addr = '0;
                    n_clr_pend = 1'b0;
                    n_state    = r_clr_pend ? S_DONE : S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_cmd      = i_cmd.cmd;
                    n_key      = i_cmd.key;
                    n_way      = WAY_NONE;
                    n_success  = 1'b0;
                    n_fail     = 1'b0;
                    n_homeless = '0;
                    if (i_cmd.cmd == CMD_CLEAR) begin
                        n_count    = '0;
                        n_clr_pend = 1'b1;
                        n_state    = S_CLR;
                    end else begin
                        mod_start = 1'b1;
                        mod_val   = f_prod_a(i_cmd.key);
                        n_state   = S_HA;
                    end
                end
            end
            S_HA: begin
                if (mod_done) begin
                    n_ha      = mod_rem;
                    mod_start = 1'b1;
                    mod_val   = f_prod_b(r_key);
                    n_state   = S_HB;
                end
            end
            S_HB: begin
                if (mod_done) begin
                    n_hb    = mod_rem;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_LOC;
            end
            S_LOC: begin
                n_way   = loc_way;
                n_state = S_DONE;
                case (r_cmd)
                    CMD_ERASE: begin
                        wdata = {1'b0, r_key};
                        if (loc_way == WAY_FIRST) begin
                            we_a  = 1'b1;
                            waddr = r_ha;
                        end else if (loc_way == WAY_SECOND) begin
                            we_b  = 1'b1;
                            waddr = r_hb;
                        end
                        if (loc_way != WAY_NONE) begin
                            n_count   = r_count - CW'(1);
                            n_success = 1'b1;
                        end
                    end
                    CMD_INSERT: begin
                        if (loc_way == WAY_NONE) begin
                            if (r_max_kicks == 8'd0) begin
                                n_fail     = 1'b1;
                                n_homeless = r_key;
                            end else begin
                                n_idx   = r_ha;
                                n_first = 1'b1;
                                n_steps = '0;
                                n_state = S_KRD;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            S_KRD: begin
                raddr_a = r_idx;
                raddr_b = r_idx;
                n_state = S_KCHK;
            end
            S_KCHK: begin
                // place the carried key; take the old one along if any
                we_a = r_first;
                we_b = !r_first;
                if (!rsel[KEY_W]) begin
                    n_count   = r_count + CW'(1);
                    n_success = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    n_key   = rsel[KEY_W-1:0];
                    n_first = !r_first;
                    n_steps = steps_inc;
                    if (steps_inc == r_max_kicks) begin
                        n_fail     = 1'b1;
                        n_homeless = rsel[KEY_W-1:0];
                        n_state    = S_DONE;
                    end else begin
                        mod_start = 1'b1;
                        mod_val   = r_first ? f_prod_b(rsel[KEY_W-1:0])
                                            : f_prod_a(rsel[KEY_W-1:0]);
                        n_state   = S_KH;
                    end
                end
            end
            S_KH: begin
                if (mod_done) begin
                    n_idx   = mod_rem;
                    n_state = S_KRD;
                end
            end
            S_DONE: begin
                if (!r_ov || o_res.ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_ov = load_out || (r_ov && !o_res.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_addr <= '0;
            r_clr_pend <= 1'b0;
            r_count    <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_clr_pend <= n_clr_pend;
            r_count    <= n_count;
            r_ov       <= n_ov;
        end
        r_cmd      <= n_cmd;
        r_key      <= n_key;
        r_ha       <= n_ha;
        r_hb       <= n_hb;
        r_idx      <= n_idx;
        r_first    <= n_first;
        r_steps    <= n_steps;
        r_way      <= n_way;
        r_success  <= n_success;
        r_fail     <= n_fail;
        r_homeless <= n_homeless;
        if (load_out) begin
            r_o_way      <= r_way;
            r_o_success  <= r_success;
            r_o_fail     <= r_fail;
            r_o_homeless <= r_homeless;
            r_o_count    <= 12'(r_count);
            r_o_load     <= 32'(r_count) > 32'(r_load_limit);
        end
    end

    assign o_res.valid        = r_ov;
    assign o_res.way          = r_o_way;
    assign o_res.success      = r_o_success;
    assign o_res.kick_fail    = r_o_fail;
    assign o_res.homeless_key = r_o_homeless;
    assign o_res.entry_count  = r_o_count;
    assign o_res.load_high    = r_o_load;
endmodule
`default_nettype wire

[src/chtb_chk.sv]
// Port-level checker for cuckoo_hash_table_core, attached by bind.
// Uses chtb_pkg for way codes.
`default_nettype none
module chtb_chk
    import chtb_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_res_valid,
    input wire logic        i_res_ready,
    input wire logic [1:0]  i_way,
    input wire logic        i_success,
    input wire logic        i_kick_fail,
    input wire logic [31:0] i_homeless_key
);
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result beat dropped while stalled");

    a_fail_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> !(i_success && i_kick_fail))
        else $error("success and kick_fail both set");

    a_homeless_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_kick_fail |-> i_homeless_key == 32'd0)
        else $error("homeless key without kick_fail");

    a_way_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_kick_fail |-> i_way == WAY_NONE)
        else $error("kick_fail on a key already stored");
endmodule

bind cuckoo_hash_table_core chtb_chk u_chtb_chk (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_res_valid(o_res.valid),
    .i_res_ready(o_res.ready),
    .i_way(o_res.way),
    .i_success(o_res.success),
    .i_kick_fail(o_res.kick_fail),
    .i_homeless_key(o_res.homeless_key)
);
`default_nettype wire
